// ===== design/dfr_pkg.sv =====
// Package for the WebSocket frame deframer: result kind codes, the item
// record that travels from parser to output stage, and queue sizing.
// No dependencies.
package dfr_pkg;

  localparam logic [2:0] KIND_DATA  = 3'd0;
  localparam logic [2:0] KIND_EMPTY = 3'd1;
  localparam logic [2:0] KIND_CLOSE = 3'd2;
  localparam logic [2:0] KIND_FRAG  = 3'd3;
  localparam logic [2:0] KIND_LONG  = 3'd4;

  // Queue between parser and output stage.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Classified item: raw byte plus the key byte to apply in the back end.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [7:0] key;
    logic       last;
  } op_t;

endpackage

// ===== design/dfr_front.sv =====
// Frame header parser: walks header, extended length and mask key, and
// classifies each accepted byte into zero or one op item.
// Depends on dfr_pkg.
module dfr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  output logic          op_valid,
  output dfr_pkg::op_t  op
);

  localparam logic [2:0] PH_HDR0   = 3'd0;
  localparam logic [2:0] PH_HDR1   = 3'd1;
  localparam logic [2:0] PH_EXT_HI = 3'd2;
  localparam logic [2:0] PH_EXT_LO = 3'd3;
  localparam logic [2:0] PH_KEY    = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;

  logic [2:0]  phase, phase_next;
  logic        is_masked, is_masked_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  key_index, key_index_next;
  logic [15:0] remaining, remaining_next;
  logic        halted, halted_next;

  logic [15:0] len_val;
  logic [15:0] rem_dec;
  logic [7:0]  key_byte;

  // Key byte 0 lives in bits 31..24.
  always_comb begin
    case (key_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  assign rem_dec = remaining - 16'd1;

  always_comb begin
    phase_next     = phase;
    is_masked_next = is_masked;
    mask_key_next  = mask_key;
    key_index_next = key_index;
    remaining_next = remaining;
    halted_next    = halted;
    op_valid       = 1'b0;
    op             = '0;
    len_val        = 16'd0;

    if (accept && !halted) begin
      case (phase)
        PH_HDR1: begin
          is_masked_next = data_byte[7];
          if (data_byte[6:0] == 7'd127) begin
            halted_next = 1'b1;
            op_valid    = 1'b1;
            op.kind     = dfr_pkg::KIND_LONG;
          end else if (data_byte[6:0] == 7'd126) begin
            phase_next = PH_EXT_HI;
          end else begin
            len_val        = {9'd0, data_byte[6:0]};
            remaining_next = len_val;
            key_index_next = 2'd0;
            if (data_byte[7]) begin
              phase_next = PH_KEY;
            end else if (len_val == 16'd0) begin
              phase_next = PH_HDR0;
              op_valid   = 1'b1;
              op.kind    = dfr_pkg::KIND_EMPTY;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_EXT_HI: begin
          remaining_next = {data_byte, 8'd0};
          phase_next     = PH_EXT_LO;
        end
        PH_EXT_LO: begin
          len_val        = {remaining[15:8], data_byte};
          remaining_next = len_val;
          key_index_next = 2'd0;
          if (is_masked) begin
            phase_next = PH_KEY;
          end else if (len_val == 16'd0) begin
            phase_next = PH_HDR0;
            op_valid   = 1'b1;
            op.kind    = dfr_pkg::KIND_EMPTY;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_KEY: begin
          case (key_index)
            2'd0:    mask_key_next[31:24] = data_byte;
            2'd1:    mask_key_next[23:16] = data_byte;
            2'd2:    mask_key_next[15:8]  = data_byte;
            default: mask_key_next[7:0]   = data_byte;
          endcase
          key_index_next = key_index + 2'd1;
          if (key_index == 2'd3) begin
            key_index_next = 2'd0;
            if (remaining == 16'd0) begin
              phase_next = PH_HDR0;
              op_valid   = 1'b1;
              op.kind    = dfr_pkg::KIND_EMPTY;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          remaining_next = rem_dec;
          key_index_next = key_index + 2'd1;
          op_valid       = 1'b1;
          op.kind        = dfr_pkg::KIND_DATA;
          op.data        = data_byte;
          op.key         = is_masked ? key_byte : 8'd0;
          op.last        = (rem_dec == 16'd0);
          if (rem_dec == 16'd0) begin
            phase_next     = PH_HDR0;
            key_index_next = 2'd0;
          end
        end
        default: begin
          // first header byte; unused phase codes land here too
          if (data_byte[3]) begin
            halted_next = 1'b1;
            op_valid    = 1'b1;
            op.kind     = dfr_pkg::KIND_CLOSE;
          end else if (!data_byte[7]) begin
            halted_next = 1'b1;
            op_valid    = 1'b1;
            op.kind     = dfr_pkg::KIND_FRAG;
          end else begin
            phase_next = PH_HDR1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR0;
      is_masked <= 1'b0;
      mask_key  <= 32'd0;
      key_index <= 2'd0;
      remaining <= 16'd0;
      halted    <= 1'b0;
    end else begin
      phase     <= phase_next;
      is_masked <= is_masked_next;
      mask_key  <= mask_key_next;
      key_index <= key_index_next;
      remaining <= remaining_next;
      halted    <= halted_next;
    end
  end

endmodule

// ===== design/dfr_fifo.sv =====
// Short queue of op items between the parser and the output stage.
// Depends on dfr_pkg.
module dfr_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  dfr_pkg::op_t  wr_op,
  input  logic          rd_en,
  output dfr_pkg::op_t  rd_op,
  output logic          q_empty,
  output logic          q_full
);

  dfr_pkg::op_t                 slots [dfr_pkg::QDEPTH];
  logic [dfr_pkg::QAW-1:0]      head;
  logic [dfr_pkg::QAW-1:0]      tail;
  logic [dfr_pkg::QCW-1:0]      count;

  logic do_wr;
  logic do_rd;

  assign q_empty = (count == '0);
  assign q_full  = (count == dfr_pkg::QCW'(dfr_pkg::QDEPTH));
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_op   = slots[head];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[tail] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        tail <= tail + 1'b1;
      end
      if (do_rd) begin
        head <= head + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/dfr_back.sv =====
// Output stage: takes op items from the queue, applies the mask key and
// holds the result item until it is popped.
// Depends on dfr_pkg.
module dfr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  dfr_pkg::op_t  q_op,
  output logic          q_rd,
  input  logic          pop,
  output logic          empty,
  output logic [2:0]    kind,
  output logic [7:0]    payload_byte,
  output logic          last
);

  logic out_valid;

  assign empty = !out_valid;
  assign q_rd  = !q_empty && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_rd) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      kind         <= q_op.kind;
      payload_byte <= q_op.data ^ q_op.key;
      last         <= q_op.last;
    end
  end

endmodule

// ===== design/websocket_frame_deframer_unit.sv =====
// WebSocket frame deframer, top level. Depends on dfr_pkg, dfr_front,
// dfr_fifo and dfr_back.
// A result item is registered in a queue slot and then in the output register before it reaches the ports.
// Throughput: one byte per cycle; full rises only when the 4-entry queue
// is full because results are not being popped.
// Reset (rst, synchronous): parser returns to the first header byte, clears
// the halt flag and key state; queue and output stage come up empty.
module websocket_frame_deframer_unit (
  input  logic       clk,
  input  logic       rst,
  // byte input, queue style
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  // result output, queue style
  output logic       empty,
  input  logic       pop,
  output logic [2:0] kind,
  output logic [7:0] payload_byte,
  output logic       last
);

  // Front end: header parser. It classifies each accepted byte and emits
  // at most one op item, which carries the raw byte and the key byte.
  logic          accept;
  logic          op_valid;
  dfr_pkg::op_t  op;

  // Queue state between parser and output stage.
  logic          q_empty;
  logic          q_full;
  logic          q_rd;
  dfr_pkg::op_t  q_op;

  // A byte is taken whenever the queue has room, even if it makes no item:
  // the parser never waits on the output side directly.
  assign full   = q_full;
  assign accept = push && !q_full;

  dfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .op_valid  (op_valid),
    .op        (op)
  );

  dfr_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (op_valid),
    .wr_op   (op),
    .rd_en   (q_rd),
    .rd_op   (q_op),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  // Back end: unmasks (XOR with key byte) and presents the oldest item;
  // if the queue holds an item, it refills in the same cycle that a pop frees it.
  dfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_op         (q_op),
    .q_rd         (q_rd),
    .pop          (pop),
    .empty        (empty),
    .kind         (kind),
    .payload_byte (payload_byte),
    .last         (last)
  );

endmodule
